// ----- rtl/oven_setpoint_keypad_timer_macros.svh -----
// assertion macros for the oven setpoint keypad timer checker
// no dependencies; included by the checker file
`ifndef OVEN_SETPOINT_KEYPAD_TIMER_MACROS_SVH
`define OVEN_SETPOINT_KEYPAD_TIMER_MACROS_SVH

// same-cycle implication
`define OSKT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OSKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/oskt_pkg.sv -----
// shared types, codes and helper functions for the oven setpoint keypad timer
// no dependencies; imported by oskt_next and oven_setpoint_keypad_timer
package oskt_pkg;

	typedef logic [3:0] digit_t;
	typedef digit_t [3:0] chain_t;
	typedef digit_t [2:0] temp_dig_t;
	typedef digit_t [6:0] digs7_t;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_PRESS   = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	localparam logic [1:0] CFG_TEMP_MAX = 2'd0;
	localparam logic [1:0] CFG_REPEAT   = 2'd1;
	localparam logic [1:0] CFG_TICKS    = 2'd2;
	localparam logic [1:0] CFG_BLINK    = 2'd3;

	// confirmed mode keys
	localparam logic [3:0] KEY_START = 4'd13;
	localparam logic [3:0] KEY_STOP  = 4'd14;
	localparam logic [3:0] KEY_EDIT  = 4'd15;
	// edit mode keys
	localparam logic [3:0] KEY_PLUS  = 4'd3;
	localparam logic [3:0] KEY_MINUS = 4'd7;
	localparam logic [3:0] KEY_CLEAR = 4'd11;
	localparam logic [3:0] KEY_LEFT  = 4'd13;
	localparam logic [3:0] KEY_RIGHT = 4'd14;
	localparam logic [3:0] KEY_ENTER = 4'd15;

	localparam logic [2:0] CUR_GAP      = 3'd3;
	localparam logic [2:0] CUR_SEC_TENS = 3'd6;
	localparam digit_t     SEC_TENS_LIM = 4'd6;

	localparam logic [9:0] TEMP_MAX_RST = 10'd250;
	localparam logic [5:0] REPEAT_RST   = 6'd32;
	localparam logic [7:0] TICKS_RST    = 8'd100;
	localparam logic [6:0] BLINK_RST    = 7'd64;

	// index 0 is the most significant digit of a chain
	localparam chain_t TEMP_RADIX = {4'd9, 4'd9, 4'd9, 4'd9};
	localparam chain_t TIME_RADIX = {4'd9, 4'd5, 4'd9, 4'd9};

	// temperature 020, time 00:00
	localparam digs7_t DIG_RST = {4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd0};

	typedef struct packed {
		digs7_t     dig;
		logic       edit;
		logic       run;
		logic [2:0] cur;
		logic [5:0] rep;
		logic [7:0] sec_ticks;
		logic [7:0] blink_ticks;
	} state_t;

	typedef struct packed {
		logic [9:0] temp_max;
		temp_dig_t  tmax_dig;
		logic [5:0] rep_thr;
		logic [7:0] tps;
		logic [6:0] blink_half;
	} cfg_t;

	typedef struct packed {
		logic   hit;
		digit_t val;
	} keyd_t;

	localparam state_t STATE_RST = '{
		dig: DIG_RST, edit: 1'b0, run: 1'b0, cur: 3'd0,
		rep: 6'd0, sec_ticks: 8'd0, blink_ticks: 8'd0
	};

	function automatic keyd_t key_digit(input logic [3:0] key);
		keyd_t r;
		r = '{hit: 1'b1, val: 4'd0};
		case (key)
			4'd0:    r.val = 4'd7;
			4'd1:    r.val = 4'd8;
			4'd2:    r.val = 4'd9;
			4'd4:    r.val = 4'd4;
			4'd5:    r.val = 4'd5;
			4'd6:    r.val = 4'd6;
			4'd8:    r.val = 4'd1;
			4'd9:    r.val = 4'd2;
			4'd10:   r.val = 4'd3;
			4'd12:   r.val = 4'd0;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// saturating one-unit step at digit k of a mixed-radix chain,
	// digits above lo are outside the chain
	function automatic chain_t bcd_step(input chain_t d, input chain_t mx,
			input logic [1:0] lo, input logic [1:0] k, input logic up);
		logic   all_max;
		logic   any_nz;
		logic   c;
		chain_t r;
		all_max = 1'b1;
		any_nz  = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (2'(i) >= lo && 2'(i) <= k) begin
				if (d[i] != mx[i]) all_max = 1'b0;
				if (d[i] != 4'd0) any_nz = 1'b1;
			end
		end
		r = d;
		c = up ? !all_max : any_nz;
		for (int i = 3; i >= 0; i--) begin
			if (c && 2'(i) >= lo && 2'(i) <= k) begin
				if (up) begin
					if (r[i] == mx[i]) begin
						r[i] = 4'd0;
					end else begin
						r[i] = r[i] + 4'd1;
						c = 1'b0;
					end
				end else begin
					if (r[i] == 4'd0) begin
						r[i] = mx[i];
					end else begin
						r[i] = r[i] - 4'd1;
						c = 1'b0;
					end
				end
			end
		end
		return r;
	endfunction

	// decimal digits of a 10-bit value, hundreds taken modulo ten
	function automatic temp_dig_t tmax_digits(input logic [9:0] v);
		logic [15:0] p1;
		logic [3:0]  h;
		logic [6:0]  rem;
		logic [14:0] p2;
		logic [3:0]  t;
		temp_dig_t   r;
		p1   = 16'(v) * 16'd41;
		h    = p1[15:12];
		rem  = 7'(v - 10'(h) * 10'd100);
		p2   = 15'(rem) * 15'd205;
		t    = p2[14:11];
		r[0] = (h == 4'd10) ? 4'd0 : h;
		r[1] = t;
		r[2] = 4'(rem - 7'(t) * 7'd10);
		return r;
	endfunction

	function automatic logic [9:0] temp_bin(input digs7_t d);
		return 10'(d[0]) * 10'd100 + 10'(d[1]) * 10'd10 + 10'(d[2]);
	endfunction

endpackage

// ----- rtl/oskt_next.sv -----
// next-state logic for one item of the oven setpoint keypad timer
// depends on oskt_pkg
module oskt_next import oskt_pkg::*; (
	input  state_t     cur_st,
	input  cfg_t       cfg,
	input  logic [1:0] op,
	input  logic [3:0] key_code,
	output state_t     nxt_st
);

	keyd_t      kd;
	chain_t     tch;
	chain_t     sch;
	chain_t     tstep;
	chain_t     sstep;
	chain_t     cnt;
	logic [2:0] cur_r;
	logic [2:0] cur_l;
	logic [2:0] cur_inc;
	logic [2:0] cur_dec;
	logic [7:0] bt_inc;
	logic [7:0] st_inc;
	logic [5:0] rep_inc;
	logic       up;
	logic       time_zero;
	logic       cnt_zero;

	assign kd = key_digit(key_code);

	assign tch = {cur_st.dig[2], cur_st.dig[1], cur_st.dig[0], 4'd0};
	assign sch = {cur_st.dig[6], cur_st.dig[5], cur_st.dig[4], cur_st.dig[3]};

	assign up    = (key_code == KEY_PLUS);
	assign tstep = bcd_step(tch, TEMP_RADIX, 2'd1, cur_st.cur[1:0] + 2'd1, up);
	assign sstep = bcd_step(sch, TIME_RADIX, 2'd0, cur_st.cur[1:0], up);
	assign cnt   = bcd_step(sch, TIME_RADIX, 2'd0, 2'd3, 1'b0);

	assign time_zero = (sch == '0);
	assign cnt_zero  = (cnt == '0);

	// cursor moves skip the gap between temperature and time
	assign cur_inc = cur_st.cur + 3'd1;
	assign cur_dec = cur_st.cur - 3'd1;
	assign cur_r   = (cur_inc == CUR_GAP) ? cur_inc + 3'd1 : cur_inc;
	assign cur_l   = (cur_dec == CUR_GAP) ? cur_dec - 3'd1 : cur_dec;

	assign bt_inc  = cur_st.blink_ticks + 8'd1;
	assign st_inc  = cur_st.sec_ticks + 8'd1;
	assign rep_inc = cur_st.rep + 6'd1;

	always_comb begin
		nxt_st = cur_st;
		case (op_t'(op))
			OP_TICK: begin
				if (cur_st.edit) begin
					nxt_st.blink_ticks = (bt_inc >= {cfg.blink_half, 1'b0}) ? 8'd0 : bt_inc;
				end
				if (cur_st.run) begin
					if (st_inc >= cfg.tps) begin
						nxt_st.sec_ticks = 8'd0;
						if (time_zero) begin
							nxt_st.run = 1'b0;
						end else begin
							nxt_st.dig[3] = cnt[0];
							nxt_st.dig[4] = cnt[1];
							nxt_st.dig[5] = cnt[2];
							nxt_st.dig[6] = cnt[3];
							if (cnt_zero) nxt_st.run = 1'b0;
						end
					end else begin
						nxt_st.sec_ticks = st_inc;
					end
				end
			end
			OP_PRESS: begin
				if (!cur_st.edit) begin
					case (key_code)
						KEY_START: nxt_st.run  = 1'b1;
						KEY_STOP:  nxt_st.run  = 1'b0;
						KEY_EDIT:  nxt_st.edit = 1'b1;
						default: ;
					endcase
				end else if (kd.hit) begin
					// seconds tens digit refuses six and up
					if (!(cur_st.cur == CUR_SEC_TENS && kd.val >= SEC_TENS_LIM)) begin
						if (cur_st.cur != CUR_GAP) begin
							nxt_st.dig[cur_st.cur[2] ? cur_st.cur - 3'd1 : cur_st.cur] = kd.val;
						end
						nxt_st.cur = cur_r;
					end
				end else begin
					case (key_code)
						KEY_PLUS, KEY_MINUS: begin
							nxt_st.rep = rep_inc;
							if (rep_inc == cfg.rep_thr) begin
								nxt_st.rep = 6'd0;
								if (cur_st.cur[2]) begin
									nxt_st.dig[3] = sstep[0];
									nxt_st.dig[4] = sstep[1];
									nxt_st.dig[5] = sstep[2];
									nxt_st.dig[6] = sstep[3];
								end else if (cur_st.cur != CUR_GAP) begin
									nxt_st.dig[0] = tstep[1];
									nxt_st.dig[1] = tstep[2];
									nxt_st.dig[2] = tstep[3];
								end
							end
						end
						KEY_CLEAR: nxt_st.dig = DIG_RST;
						KEY_LEFT:  nxt_st.cur = cur_l;
						KEY_RIGHT: nxt_st.cur = cur_r;
						KEY_ENTER: begin
							if (temp_bin(cur_st.dig) > cfg.temp_max) begin
								nxt_st.dig[0] = cfg.tmax_dig[0];
								nxt_st.dig[1] = cfg.tmax_dig[1];
								nxt_st.dig[2] = cfg.tmax_dig[2];
							end
							nxt_st.edit = 1'b0;
						end
						default: ;
					endcase
				end
			end
			OP_RELEASE: nxt_st.rep = 6'd0;
			default: ;
		endcase
	end

endmodule

// ----- rtl/oven_setpoint_keypad_timer.sv -----
// top level of the oven setpoint keypad timer: input register, state/result register
// depends on oskt_pkg and oskt_next
//
// usage:
// - input channel (in_valid, in_stall, op, key_code) carries tick, key press and
//   key release events; each event gives exactly one result item
// - output channel (out_valid, out_stall) shows the digits, mode, cursor and blink
//   state after the event
// - flow: an accepted item waits in the input register, then enters the state register
//   when no result is pending or it is taken; one item per cycle sustained while the
//   receiver does not stall, set by the single state update path between the registers
// - the state register is the result register; while the receiver stalls the
//   result holds, and one more item waits in the input register before in_stall rises
// - the user must write configuration (cfg_we, cfg_index, cfg_wdata) only while idle;
//   unenforced; the temp clamp is also kept as decimal digits, converted at the write
// - reset: setpoint 020 and 00:00, confirmed mode, stopped, cursor 0, counters clear,
//   registers back to 250, 32, 100 and 64; no item is pending
module oven_setpoint_keypad_timer import oskt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [3:0] key_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] temp_hundreds,
	output logic [3:0] temp_tens,
	output logic [3:0] temp_ones,
	output logic [3:0] minute_tens,
	output logic [3:0] minute_ones,
	output logic [2:0] second_tens,
	output logic [3:0] second_ones,
	output logic       running,
	output logic       editing,
	output logic [2:0] cursor,
	output logic       blank_cursor,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_wdata
);

	cfg_t       cfg_q;
	state_t     st_q;
	state_t     st_d;
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [3:0] key_s1;
	logic       out_valid_q;
	logic       blank_q;
	logic       adv;
	logic       take;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_max   <= TEMP_MAX_RST;
			cfg_q.tmax_dig   <= tmax_digits(TEMP_MAX_RST);
			cfg_q.rep_thr    <= REPEAT_RST;
			cfg_q.tps        <= TICKS_RST;
			cfg_q.blink_half <= BLINK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP_MAX: begin
					cfg_q.temp_max <= cfg_wdata;
					cfg_q.tmax_dig <= tmax_digits(cfg_wdata);
				end
				CFG_REPEAT: cfg_q.rep_thr    <= cfg_wdata[5:0];
				CFG_TICKS:  cfg_q.tps        <= cfg_wdata[7:0];
				CFG_BLINK:  cfg_q.blink_half <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= op;
			key_s1 <= key_code;
		end
	end

	oskt_next u_next (
		.cur_st   (st_q),
		.cfg      (cfg_q),
		.op       (op_s1),
		.key_code (key_s1),
		.nxt_st   (st_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RST;
			blank_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			st_q        <= st_d;
			blank_q     <= st_d.edit && (st_d.blink_ticks >= {1'b0, cfg_q.blink_half});
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign temp_hundreds = st_q.dig[0];
	assign temp_tens     = st_q.dig[1];
	assign temp_ones     = st_q.dig[2];
	assign minute_tens   = st_q.dig[3];
	assign minute_ones   = st_q.dig[4];
	assign second_tens   = st_q.dig[5][2:0];
	assign second_ones   = st_q.dig[6];
	assign running       = st_q.run;
	assign editing       = st_q.edit;
	assign cursor        = st_q.cur;
	assign blank_cursor  = blank_q;

endmodule

// ----- rtl/oskt_checker.sv -----
// port-level checks for the oven setpoint keypad timer, bound to the top level
// depends on oven_setpoint_keypad_timer_macros.svh
`include "oven_setpoint_keypad_timer_macros.svh"

module oskt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] temp_hundreds,
	input logic [3:0] temp_tens,
	input logic [3:0] temp_ones,
	input logic [3:0] minute_tens,
	input logic [3:0] minute_ones,
	input logic [2:0] second_tens,
	input logic [3:0] second_ones,
	input logic       running,
	input logic       editing,
	input logic [2:0] cursor,
	input logic       blank_cursor
);

	// a stalled result item holds
	`OSKT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(cursor) && $stable(temp_ones) && $stable(second_ones)
		&& $stable(editing) && $stable(running), "stalled result changed")

	// input only backs up behind a stalled result
	`OSKT_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall,
		out_valid && out_stall, "input stalled without a stalled result")

	`OSKT_ASSERT_SAME(a_cursor_gap, clk, arst_n, out_valid,
		cursor != 3'd3, "cursor on the gap position")

	`OSKT_ASSERT_SAME(a_digits, clk, arst_n, out_valid,
		temp_hundreds <= 4'd9 && temp_tens <= 4'd9 && temp_ones <= 4'd9
		&& minute_tens <= 4'd9 && minute_ones <= 4'd9 && second_tens <= 3'd5
		&& second_ones <= 4'd9, "digit out of decimal range")

	`OSKT_ASSERT_SAME(a_blank_mode, clk, arst_n, out_valid && blank_cursor,
		editing, "cursor blanked outside edit mode")

endmodule

bind oven_setpoint_keypad_timer oskt_checker u_oskt_checker (.*);

// ----- bench/oven_setpoint_keypad_timer_tb.sv -----
// self-checking testbench for oven_setpoint_keypad_timer: directed keypad, cursor,
// step and countdown tests, then random phases over several register settings
// depends on oskt_pkg and the oven_setpoint_keypad_timer rtl
`timescale 1ns / 100ps

module oven_setpoint_keypad_timer_tb;
	import oskt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [3:0] DIGIT_KEYS [10] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6,
		4'd8, 4'd9, 4'd10, 4'd12};

	typedef struct packed {
		logic [3:0] t_hun;
		logic [3:0] t_ten;
		logic [3:0] t_one;
		logic [3:0] m_ten;
		logic [3:0] m_one;
		logic [2:0] s_ten;
		logic [3:0] s_one;
		logic       run;
		logic       edit;
		logic [2:0] cur;
		logic       blank;
	} readout_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] op = OP_TICK;
	logic [3:0] key_code = 4'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] temp_hundreds;
	logic [3:0] temp_tens;
	logic [3:0] temp_ones;
	logic [3:0] minute_tens;
	logic [3:0] minute_ones;
	logic [2:0] second_tens;
	logic [3:0] second_ones;
	logic       running;
	logic       editing;
	logic [2:0] cursor;
	logic       blank_cursor;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_TEMP_MAX;
	logic [9:0] cfg_wdata = 10'd0;

	oven_setpoint_keypad_timer u_top (.*);

	// predicted oven state and registers
	logic [3:0] setpt [7];
	logic       edit_on;
	logic       run_on;
	logic [2:0] cur_pos;
	logic [5:0] hold_cnt;
	logic [7:0] sec_cnt;
	logic [7:0] blink_cnt;
	logic [9:0] cfg_tmax;
	logic [5:0] cfg_thr;
	logic [7:0] cfg_tps;
	logic [6:0] cfg_blink;

	readout_t    readout_q [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	bit          idle_on = 1'b1;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("oven_setpoint_keypad_timer_tb NOT OK");
		$finish;
	end

	function automatic int keypad_value(input logic [3:0] k);
		case (k)
			4'd0:    return 7;
			4'd1:    return 8;
			4'd2:    return 9;
			4'd4:    return 4;
			4'd5:    return 5;
			4'd6:    return 6;
			4'd8:    return 1;
			4'd9:    return 2;
			4'd10:   return 3;
			4'd12:   return 0;
			default: return -1;
		endcase
	endfunction

	function automatic int temp_of();
		return setpt[0] * 100 + setpt[1] * 10 + setpt[2];
	endfunction

	function automatic int secs_of();
		return (setpt[3] * 10 + setpt[4]) * 60 + setpt[5] * 10 + setpt[6];
	endfunction

	task automatic put_temp(input int v);
		setpt[0] = 4'((v / 100) % 10);
		setpt[1] = 4'((v / 10) % 10);
		setpt[2] = 4'(v % 10);
	endtask

	task automatic put_secs(input int v);
		setpt[3] = 4'((v / 600) % 10);
		setpt[4] = 4'((v / 60) % 10);
		setpt[5] = 4'((v / 10) % 6);
		setpt[6] = 4'(v % 10);
	endtask

	task automatic load_defaults();
		foreach (setpt[i]) setpt[i] = 4'd0;
		setpt[1] = 4'd2;
	endtask

	task automatic move_right();
		cur_pos = cur_pos + 3'd1;
		if (cur_pos == CUR_GAP) cur_pos = CUR_GAP + 3'd1;
	endtask

	task automatic move_left();
		cur_pos = cur_pos - 3'd1;
		if (cur_pos == CUR_GAP) cur_pos = CUR_GAP - 3'd1;
	endtask

	task automatic reset_oven();
		cfg_tmax  = TEMP_MAX_RST;
		cfg_thr   = REPEAT_RST;
		cfg_tps   = TICKS_RST;
		cfg_blink = BLINK_RST;
		edit_on   = 1'b0;
		run_on    = 1'b0;
		cur_pos   = 3'd0;
		hold_cnt  = 6'd0;
		sec_cnt   = 8'd0;
		blink_cnt = 8'd0;
		load_defaults();
	endtask

	// saturating step of the digit under the cursor
	task automatic step_setpt(input bit up);
		int v;
		int s;
		int lim;
		if (cur_pos < CUR_GAP) begin
			v = temp_of();
			case (cur_pos)
				3'd0:    begin s = 100; lim = 900; end
				3'd1:    begin s = 10;  lim = 990; end
				default: begin s = 1;   lim = 999; end
			endcase
		end else begin
			v = secs_of();
			case (cur_pos)
				3'd4:         begin s = 600; lim = 5400; end
				3'd5:         begin s = 60;  lim = 5940; end
				CUR_SEC_TENS: begin s = 10;  lim = 5990; end
				default:      begin s = 1;   lim = 5999; end
			endcase
		end
		if (up) begin
			if (v < lim) v = v + s;
		end else if (v >= s) begin
			v = v - s;
		end
		if (cur_pos < CUR_GAP) put_temp(v);
		else put_secs(v);
	endtask

	task automatic press_key(input logic [3:0] k);
		int d;
		int t;
		d = keypad_value(k);
		if (!edit_on) begin
			if (k == KEY_START) run_on = 1'b1;
			else if (k == KEY_STOP) run_on = 1'b0;
			else if (k == KEY_EDIT) edit_on = 1'b1;
		end else if (d >= 0) begin
			if (!(cur_pos == CUR_SEC_TENS && d >= SEC_TENS_LIM)) begin
				if (cur_pos < CUR_GAP) setpt[cur_pos] = 4'(d);
				else if (cur_pos > CUR_GAP) setpt[cur_pos - 3'd1] = 4'(d);
				move_right();
			end
		end else begin
			case (k)
				KEY_PLUS, KEY_MINUS: begin
					hold_cnt = hold_cnt + 6'd1;
					if (hold_cnt == cfg_thr) begin
						hold_cnt = 6'd0;
						step_setpt(k == KEY_PLUS);
					end
				end
				KEY_CLEAR: load_defaults();
				KEY_LEFT:  move_left();
				KEY_RIGHT: move_right();
				KEY_ENTER: begin
					t = temp_of();
					if (t > int'(cfg_tmax)) t = int'(cfg_tmax);
					put_temp(t);
					edit_on = 1'b0;
				end
				default: ;
			endcase
		end
	endtask

	task automatic tick_oven();
		int t;
		if (edit_on) begin
			blink_cnt = blink_cnt + 8'd1;
			if (blink_cnt >= 2 * cfg_blink) blink_cnt = 8'd0;
		end
		if (run_on) begin
			sec_cnt = sec_cnt + 8'd1;
			if (sec_cnt >= cfg_tps) begin
				sec_cnt = 8'd0;
				t = secs_of();
				if (t == 0) begin
					run_on = 1'b0;
				end else begin
					t = t - 1;
					put_secs(t);
					if (t == 0) run_on = 1'b0;
				end
			end
		end
	endtask

	// applies one item and queues the readout it should produce
	task automatic advance_oven(input logic [1:0] item_op, input logic [3:0] item_key);
		readout_t r;
		case (item_op)
			OP_TICK:    tick_oven();
			OP_PRESS:   press_key(item_key);
			OP_RELEASE: hold_cnt = 6'd0;
			default: ;
		endcase
		r = {setpt[0], setpt[1], setpt[2], setpt[3], setpt[4], setpt[5][2:0], setpt[6],
			run_on, edit_on, cur_pos, edit_on && (blink_cnt >= cfg_blink)};
		readout_q.push_back(r);
	endtask

	task automatic send_item(input logic [1:0] item_op, input logic [3:0] item_key);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = idle_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= item_op;
		key_code <= item_key;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_oven(item_op, item_key);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (readout_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_TEMP_MAX: cfg_tmax = data;
			CFG_REPEAT:   cfg_thr = data[5:0];
			CFG_TICKS:    cfg_tps = data[7:0];
			CFG_BLINK:    cfg_blink = data[6:0];
			default: ;
		endcase
	endtask

	// unused upper data bits are random
	task automatic set_config(input logic [9:0] tmax, input logic [5:0] thr,
			input logic [7:0] tps, input logic [6:0] bh);
		write_reg(CFG_TEMP_MAX, tmax);
		write_reg(CFG_REPEAT, {4'($urandom), thr});
		write_reg(CFG_TICKS, {2'($urandom), tps});
		write_reg(CFG_BLINK, {3'($urandom), bh});
		cfg_we <= 1'b0;
	endtask

	task automatic enter_edit_mode();
		if (!edit_on) send_item(OP_PRESS, KEY_EDIT);
	endtask

	task automatic test_idle_events();
		send_item(OP_UNUSED, KEY_EDIT);
		send_item(OP_RELEASE, KEY_PLUS);
		send_item(OP_PRESS, 4'd5);
	endtask

	// start with a zero time stops on the next second
	task automatic test_zero_countdown();
		send_item(OP_PRESS, KEY_START);
		send_item(OP_TICK, 4'd0);
	endtask

	task automatic test_entry_and_cursor();
		send_item(OP_PRESS, KEY_EDIT);
		send_item(OP_PRESS, 4'd1);
		send_item(OP_PRESS, 4'd2);
		send_item(OP_PRESS, 4'd0);
		send_item(OP_PRESS, 4'd12);
		send_item(OP_PRESS, 4'd8);
		send_item(OP_PRESS, 4'd6);
		send_item(OP_PRESS, 4'd4);
		send_item(OP_PRESS, 4'd10);
		send_item(OP_PRESS, KEY_LEFT);
		send_item(OP_PRESS, KEY_RIGHT);
	endtask

	task automatic test_setpoint_steps();
		send_item(OP_PRESS, KEY_PLUS);
		send_item(OP_PRESS, KEY_PLUS);
		send_item(OP_PRESS, KEY_LEFT);
		send_item(OP_PRESS, KEY_MINUS);
		send_item(OP_RELEASE, KEY_MINUS);
		repeat (4) send_item(OP_PRESS, KEY_LEFT);
		send_item(OP_PRESS, KEY_MINUS);
		send_item(OP_PRESS, KEY_ENTER);
	endtask

	task automatic test_short_countdown();
		send_item(OP_PRESS, KEY_EDIT);
		send_item(OP_PRESS, KEY_CLEAR);
		while (cur_pos != 3'd7) send_item(OP_PRESS, KEY_RIGHT);
		send_item(OP_PRESS, 4'd9);
		send_item(OP_PRESS, KEY_ENTER);
		send_item(OP_PRESS, KEY_START);
		repeat (3) send_item(OP_TICK, 4'd15);
	endtask

	task automatic run_random(input int n);
		int         stop_at;
		int         pick;
		int         reps;
		logic [3:0] k;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				repeat ($urandom_range(1, 8)) send_item(OP_TICK, 4'($urandom));
			end else if (pick < 45) begin
				send_item(OP_PRESS, 4'($urandom));
			end else if (pick < 60) begin
				// held plus or minus key
				enter_edit_mode();
				repeat ($urandom_range(0, 3)) send_item(OP_PRESS, KEY_RIGHT);
				k = $urandom_range(0, 1) ? KEY_PLUS : KEY_MINUS;
				reps = (cfg_thr == 6'd0) ? 70 : 2 * cfg_thr + 2;
				if (reps > 70) reps = 70;
				repeat ($urandom_range(1, reps)) send_item(OP_PRESS, k);
				if ($urandom_range(0, 4) != 0) send_item(OP_RELEASE, 4'($urandom));
			end else if (pick < 70) begin
				// short cook time, then run it down
				enter_edit_mode();
				send_item(OP_PRESS, KEY_CLEAR);
				while (cur_pos != 3'd7) send_item(OP_PRESS, KEY_LEFT);
				send_item(OP_PRESS, DIGIT_KEYS[$urandom_range(0, 9)]);
				if ($urandom_range(0, 1)) send_item(OP_PRESS, DIGIT_KEYS[$urandom_range(0, 9)]);
				send_item(OP_PRESS, KEY_ENTER);
				send_item(OP_PRESS, KEY_START);
				repeat ($urandom_range(2, 24)) send_item(OP_TICK, 4'($urandom));
			end else if (pick < 82) begin
				enter_edit_mode();
				repeat ($urandom_range(1, 8)) send_item(OP_PRESS, DIGIT_KEYS[$urandom_range(0, 9)]);
				if ($urandom_range(0, 1)) send_item(OP_PRESS, KEY_ENTER);
			end else if (pick < 92) begin
				send_item(OP_RELEASE, 4'($urandom));
			end else begin
				send_item(OP_UNUSED, 4'($urandom));
			end
		end
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			case (p)
				0: set_config(TEMP_MAX_RST, REPEAT_RST, TICKS_RST, BLINK_RST);
				1: set_config(10'd0, 6'd1, 8'd1, 7'd1);
				2: set_config(10'd999, 6'd63, 8'd255, 7'd127);
				3: set_config(10'($urandom_range(0, 999)), 6'd0, 8'd0, 7'd0);
				4: set_config(10'd123, 6'd5, 8'd2, 7'd3);
				default: set_config(10'($urandom_range(0, 999)), 6'($urandom_range(1, 8)),
					8'($urandom_range(1, 10)), 7'($urandom_range(1, 127)));
			endcase
			idle_on = (p % 3 != 1);
			run_random(170);
		end
	endtask

	task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= ~out_stall;
		endcase
	end

	always @(posedge clk) begin
		readout_t seen;
		readout_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {temp_hundreds, temp_tens, temp_ones, minute_tens, minute_ones, second_tens,
				second_ones, running, editing, cursor, blank_cursor};
			if (readout_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result item with nothing expected");
			end else begin
				want = readout_q.pop_front();
				check_field("temp_hundreds", want.t_hun, seen.t_hun);
				check_field("temp_tens", want.t_ten, seen.t_ten);
				check_field("temp_ones", want.t_one, seen.t_one);
				check_field("minute_tens", want.m_ten, seen.m_ten);
				check_field("minute_ones", want.m_one, seen.m_one);
				check_field("second_tens", 4'(want.s_ten), 4'(seen.s_ten));
				check_field("second_ones", want.s_one, seen.s_one);
				check_field("running", 4'(want.run), 4'(seen.run));
				check_field("editing", 4'(want.edit), 4'(seen.edit));
				check_field("cursor", 4'(want.cur), 4'(seen.cur));
				check_field("blank_cursor", 4'(want.blank), 4'(seen.blank));
			end
		end
	end

	initial begin
		reset_oven();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_events();
		wait_idle();
		set_config(TEMP_MAX_RST, 6'd1, 8'd1, 7'd1);
		test_zero_countdown();
		test_entry_and_cursor();
		test_setpoint_steps();
		test_short_countdown();
		test_random_phases();
		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && readout_q.size() == 0)
			$display("oven_setpoint_keypad_timer_tb OK");
		else
			$display("oven_setpoint_keypad_timer_tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/oskt_pkg.sv
rtl/oskt_next.sv
rtl/oven_setpoint_keypad_timer.sv
rtl/oskt_checker.sv
bench/oven_setpoint_keypad_timer_tb.sv
